>>> hw/rtl/swd_pkg.sv
package swd_pkg;

    localparam int TIME_BITS_DEF = 48;

    localparam int CMD_W      = 3;
    localparam int TIMEOUT_W  = 32;
    localparam int SCALE_W    = 16;
    localparam int PAUSE_W    = 16;
    localparam int SCALED_W   = TIMEOUT_W + SCALE_W;
    // scaled timeout is Q.8; full threshold drops 8 fraction bits
    localparam int THR_W      = SCALED_W - 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TIMEOUT_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 32'd30000000;
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 16'd256;
    localparam logic [SCALED_W-1:0]  SCALED_RST  =
        SCALED_W'(TIMEOUT_RST) * SCALED_W'(SCALE_RST);
    localparam logic [TIMEOUT_W-1:0] NEED_RST    = TIMEOUT_RST / 2 + TIMEOUT_RST % 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 3'd0,
        CMD_KICK   = 3'd1,
        CMD_CHECK  = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_RESUME = 3'd4,
        CMD_QUERY  = 3'd5
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 1'b0,
        REG_SCALE   = 1'b1
    } t_reg;

    typedef struct packed {
        logic [THR_W-1:0]     thr_half;
        logic [THR_W-1:0]     thr_full;
        logic [TIMEOUT_W-1:0] need_half;
    } t_thresh;

endpackage

>>> hw/rtl/swd_if.sv
interface swd_evt_if import swd_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [TIME_BITS-1:0] now;

    modport source (output valid, cmd, now, input ready);
    modport sink   (input valid, cmd, now, output ready);
endinterface

interface swd_res_if import swd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               fired;
    logic               expired;
    logic               stalled_half;
    logic [PAUSE_W-1:0] pause_before;

    modport source (output valid, fired, expired, stalled_half, pause_before, input ready);
    modport sink   (input valid, fired, expired, stalled_half, pause_before, output ready);
endinterface

>>> hw/rtl/stall_watchdog_with_gap_compensation.sv
// An accepted request goes through the input register and then the result register.
// Throughput: 1 request per cycle unless stalled; the single update stage reads and writes
// the watchdog state in the same cycle, so back-to-back requests see each other's effects.
// Reset (synchronous, active low): kick/check times, saved gap and pause count cleared,
// timeout 30000000 ticks, speed scale 1.0; both request stages empty.
module stall_watchdog_with_gap_compensation import swd_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    swd_evt_if.sink               i_evt,
    swd_res_if.source             o_res
);

    t_thresh thr;

    swd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (thr)
    );

    swd_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_thr          (thr),
        .i_in_valid     (i_evt.valid),
        .o_in_ready     (i_evt.ready),
        .i_cmd          (i_evt.cmd),
        .i_now          (i_evt.now),
        .o_out_valid    (o_res.valid),
        .i_out_ready    (o_res.ready),
        .o_fired        (o_res.fired),
        .o_expired      (o_res.expired),
        .o_stalled_half (o_res.stalled_half),
        .o_pause_before (o_res.pause_before)
    );

endmodule

>>> hw/rtl/swd_cfg.sv
module swd_cfg import swd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_thresh               o_thr
);

    logic [TIMEOUT_W-1:0] r_timeout, n_timeout;
    logic [SCALE_W-1:0]   r_scale, n_scale;
    logic [SCALED_W-1:0]  r_scaled;
    logic [TIMEOUT_W-1:0] r_need;
    logic [TIMEOUT_W:0]   need_sum;

    always_comb begin
        n_timeout = r_timeout;
        n_scale   = r_scale;
        if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_idx))
                REG_TIMEOUT: n_timeout = i_cfg_data[TIMEOUT_W-1:0];
                REG_SCALE:   n_scale   = i_cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    // ceil(timeout / 2)
    assign need_sum = {1'b0, n_timeout} + (TIMEOUT_W+1)'(1);

    // derived thresholds follow the registers with no extra lag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_scale   <= SCALE_RST;
            r_scaled  <= SCALED_RST;
            r_need    <= NEED_RST;
        end else begin
            r_timeout <= n_timeout;
            r_scale   <= n_scale;
            r_scaled  <= SCALED_W'(n_timeout) * SCALED_W'(n_scale);
            r_need    <= need_sum[TIMEOUT_W:1];
        end
    end

    assign o_thr.thr_full  = r_scaled[SCALED_W-1:8];
    assign o_thr.thr_half  = THR_W'(r_scaled[SCALED_W-1:9]);
    assign o_thr.need_half = r_need;

endmodule

>>> hw/rtl/swd_core.sv
module swd_core import swd_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_thresh              i_thr,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [TIME_BITS-1:0] i_now,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_fired,
    output logic                 o_expired,
    output logic                 o_stalled_half,
    output logic [PAUSE_W-1:0]   o_pause_before
);

    localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

    logic                 r_in_valid;
    logic [CMD_W-1:0]     r_cmd;
    logic [TIME_BITS-1:0] r_now;

    logic                 r_out_valid;
    logic                 r_fired, n_fired;
    logic                 r_expired, n_expired;
    logic                 r_half, n_half;
    logic [PAUSE_W-1:0]   r_before, n_before;

    logic [TIME_BITS-1:0] r_last_kick, n_last_kick;
    logic [TIME_BITS-1:0] r_last_check, n_last_check;
    logic [TIME_BITS-1:0] r_gap, n_gap;
    logic [PAUSE_W-1:0]   r_pause, n_pause;

    logic                 advance;
    logic                 in_take;

    logic                 kick_ok;
    logic [TIME_BITS-1:0] span_check;
    logic [TIME_BITS-1:0] span_pulse;
    logic [TIME_BITS:0]   gap_sum;
    logic [TIME_BITS-1:0] total;
    logic [TIME_BITS-1:0] remain;
    logic                 stall;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;

    assign kick_ok    = r_now >= r_last_kick;
    assign span_check = (r_now >= r_last_check) ? (r_now - r_last_check) : '0;
    assign span_pulse = kick_ok ? (r_now - r_last_kick) : '0;

    // saturating gap + interval; same sum serves the new saved gap
    assign gap_sum = {1'b0, span_check} + {1'b0, r_gap};
    assign total   = gap_sum[TIME_BITS] ? '1 : gap_sum[TIME_BITS-1:0];
    assign remain  = span_pulse - total;
    assign stall   = (span_pulse > total) && (CMP_W'(remain) > CMP_W'(i_thr.thr_full));

    always_comb begin
        n_last_kick  = r_last_kick;
        n_last_check = r_last_check;
        n_gap        = r_gap;
        n_pause      = r_pause;
        n_fired      = 1'b0;
        n_expired    = 1'b0;
        n_half       = 1'b0;
        n_before     = '0;
        unique case (t_cmd'(r_cmd))
            CMD_START: begin
                n_last_kick  = r_now;
                n_last_check = r_now;
                n_gap        = '0;
            end
            CMD_KICK: begin
                n_last_kick = r_now;
                n_gap       = '0;
            end
            CMD_CHECK: begin
                n_last_check = r_now;
                if (CMP_W'(span_check) > CMP_W'(i_thr.thr_half)) begin
                    n_gap = total;
                end
                if (stall) begin
                    n_expired   = 1'b1;
                    n_fired     = (r_pause == '0);
                    n_last_kick = r_now;
                    n_gap       = '0;
                end
            end
            CMD_PAUSE: begin
                if (r_pause != '1) begin
                    n_pause = r_pause + PAUSE_W'(1);
                end
            end
            CMD_RESUME: begin
                n_before = r_pause;
                if (r_pause != '0) begin
                    n_pause = r_pause - PAUSE_W'(1);
                end
            end
            CMD_QUERY: begin
                n_half = kick_ok &&
                    (CMP_W'(span_pulse) >= CMP_W'(i_thr.need_half));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_last_kick  <= '0;
            r_last_check <= '0;
            r_gap        <= '0;
            r_pause      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_last_kick  <= n_last_kick;
                r_last_check <= n_last_check;
                r_gap        <= n_gap;
                r_pause      <= n_pause;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= i_cmd;
            r_now <= i_now;
        end
        if (advance) begin
            r_fired   <= n_fired;
            r_expired <= n_expired;
            r_half    <= n_half;
            r_before  <= n_before;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fired        = r_fired;
    assign o_expired      = r_expired;
    assign o_stalled_half = r_half;
    assign o_pause_before = r_before;

endmodule

>>> hw/rtl/swd_check.sv
module swd_check import swd_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_fired,
    input logic               i_expired,
    input logic               i_stalled_half,
    input logic [PAUSE_W-1:0] i_pause_before
);

    // a firing check is always an expiring one
    a_fire_needs_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_fired || i_expired))
        else $error("fired without expired");

    // each result comes from one command, so at most one kind of answer is set
    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($countones({i_expired, i_stalled_half, i_pause_before != '0}) <= 1))
        else $error("result carries answers of more than one command");

    // nothing leaves the block in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_fired) &&
            $stable(i_expired) && $stable(i_stalled_half) && $stable(i_pause_before)))
        else $error("stalled result changed");

endmodule

bind stall_watchdog_with_gap_compensation swd_check u_swd_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_fired        (o_res.fired),
    .i_expired      (o_res.expired),
    .i_stalled_half (o_res.stalled_half),
    .i_pause_before (o_res.pause_before)
);
